>>> rtl/sgrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgrr_pkg
// Shared types, constants and the 5x7 font table of the glyph rasterizer.
// ----------------------------------------------------------------------------
package sgrr_pkg;

  localparam int unsigned SCREEN_W_DEF = 240;
  localparam int unsigned SCREEN_H_DEF = 240;

  // signed coordinate width: 16-bit position plus up to 6*255 plus scale
  localparam int unsigned CW = 18;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;
  localparam int unsigned NUM_COLS  = 5;
  localparam int unsigned NUM_ROWS  = 7;
  localparam int unsigned NUM_DOTS  = NUM_COLS * NUM_ROWS;
  localparam int unsigned NUM_GLYPHS = 95;

  localparam logic [2:0] COL_LAST = 3'(NUM_COLS - 1);
  localparam logic [2:0] ROW_LAST = 3'(NUM_ROWS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic last_dot;
  } status_t;

  // one entry per glyph: {col0, col1, col2, col3, col4}, bit 0 of a column is the top row
  localparam logic [39:0] GLYPH_ROM [NUM_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h1008081008
  };

endpackage
`default_nettype wire

>>> rtl/sgrr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgrr_ctrl
// Sequencer: loads a character, scans its 35 dots, then issues the closing item.
// ----------------------------------------------------------------------------
module sgrr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire sgrr_pkg::status_t status_i,
  output sgrr_pkg::cmd_t       cmd_o
);

  sgrr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgrr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sgrr_pkg::ST_IDLE: begin
        if (start) state_d = sgrr_pkg::ST_SCAN;
      end
      sgrr_pkg::ST_SCAN: begin
        if (status_i.last_dot) state_d = sgrr_pkg::ST_CLOSE;
      end
      sgrr_pkg::ST_CLOSE: begin
        state_d = start ? sgrr_pkg::ST_SCAN : sgrr_pkg::ST_IDLE;
      end
      default: state_d = sgrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    case (state_q)
      sgrr_pkg::ST_IDLE: begin
        cmd_o.load = start;
      end
      sgrr_pkg::ST_SCAN: begin
        busy       = 1'b1;
        cmd_o.step = 1'b1;
      end
      sgrr_pkg::ST_CLOSE: begin
        cmd_o.close = 1'b1;
        cmd_o.load  = start;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sgrr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgrr_dpath
// Glyph dot register, coordinate accumulators, clipping and the result register.
// ----------------------------------------------------------------------------
module sgrr_dpath #(
  parameter int unsigned SCREEN_W = sgrr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = sgrr_pkg::SCREEN_H_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sgrr_pkg::cmd_t     cmd_i,
  output sgrr_pkg::status_t       status_o,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [7:0]         scale_i,
  input  wire logic [15:0]        colour_i,
  output logic                    valid_o,
  output logic [7:0]              rect_x_o,
  output logic [7:0]              rect_y_o,
  output logic [7:0]              rect_w_o,
  output logic [7:0]              rect_h_o,
  output logic [15:0]             rect_colour_o,
  output logic                    has_rect_o,
  output logic [10:0]             advance_o,
  output logic                    last_o
);

  localparam int unsigned CW = sgrr_pkg::CW;
  localparam int unsigned ND = sgrr_pkg::NUM_DOTS;
  localparam logic signed [CW-1:0] LIM_X = CW'(SCREEN_W);
  localparam logic signed [CW-1:0] LIM_Y = CW'(SCREEN_H);

  logic [ND-1:0]          dots_q, dots_d;
  logic signed [CW-1:0]   x_q, x_d, y_q, y_d, y0_q;
  logic [7:0]             sc_q;
  logic [15:0]            rgb_q;
  logic [2:0]             col_q, col_d, row_q, row_d;

  logic                   code_ok;
  logic [6:0]             glyph_idx;
  logic [39:0]            glyph;
  logic [ND-1:0]          dots_new;

  logic signed [CW-1:0]   sc_w, x_hi, y_hi, xa, xb, ya, yb, xw, yh;
  logic                   hit;

  logic                   valid_q;
  logic [7:0]             rx_q, ry_q, rw_q, rh_q;
  logic [15:0]            rc_q;
  logic                   has_q, last_q;
  logic [10:0]            adv_q;

  assign code_ok   = (char_code_i >= sgrr_pkg::CODE_FIRST) &&
                     (char_code_i <= sgrr_pkg::CODE_LAST) && (scale_i != 8'd0);
  assign glyph_idx = 7'(char_code_i - sgrr_pkg::CODE_FIRST);
  assign glyph     = sgrr_pkg::GLYPH_ROM[glyph_idx];

  // scan order: column outer, row inner, bit 0 first
  always_comb begin
    dots_new = '0;
    for (int c = 0; c < sgrr_pkg::NUM_COLS; c++) begin
      for (int r = 0; r < sgrr_pkg::NUM_ROWS; r++) begin
        dots_new[c*sgrr_pkg::NUM_ROWS + r] = glyph[39 - 8*c - 7 + r] & code_ok;
      end
    end
  end

  assign sc_w = CW'({1'b0, sc_q});
  assign status_o.last_dot = (col_q == sgrr_pkg::COL_LAST) && (row_q == sgrr_pkg::ROW_LAST);

  always_comb begin
    dots_d = dots_q;
    x_d    = x_q;
    y_d    = y_q;
    col_d  = col_q;
    row_d  = row_q;
    if (cmd_i.step) begin
      dots_d = dots_q >> 1;
      if (row_q == sgrr_pkg::ROW_LAST) begin
        row_d = 3'd0;
        col_d = col_q + 3'd1;
        x_d   = x_q + sc_w;
        y_d   = y0_q;
      end else begin
        row_d = row_q + 3'd1;
        y_d   = y_q + sc_w;
      end
    end
    if (cmd_i.load) begin
      dots_d = dots_new;
      x_d    = CW'(pos_x_i);
      y_d    = CW'(pos_y_i);
      col_d  = 3'd0;
      row_d  = 3'd0;
    end
  end

  // clip both spans
  always_comb begin
    x_hi = x_q + sc_w;
    y_hi = y_q + sc_w;
    xa   = x_q[CW-1] ? '0 : x_q;
    ya   = y_q[CW-1] ? '0 : y_q;
    xb   = (x_hi > LIM_X) ? LIM_X : x_hi;
    yb   = (y_hi > LIM_Y) ? LIM_Y : y_hi;
    xw   = xb - xa;
    yh   = yb - ya;
    hit  = dots_q[0] && (xb > xa) && (yb > ya);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= 3'd0;
      row_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= (cmd_i.step && hit) || cmd_i.close;
    end
  end

  always_ff @(posedge clk_i) begin
    dots_q <= dots_d;
    x_q    <= x_d;
    y_q    <= y_d;
    if (cmd_i.load) begin
      y0_q  <= CW'(pos_y_i);
      sc_q  <= scale_i;
      rgb_q <= colour_i;
    end
    if (cmd_i.close) begin
      rx_q   <= '0;
      ry_q   <= '0;
      rw_q   <= '0;
      rh_q   <= '0;
      rc_q   <= '0;
      has_q  <= 1'b0;
      last_q <= 1'b1;
      adv_q  <= {1'b0, sc_q, 2'b00} + {2'b00, sc_q, 1'b0};
    end else if (cmd_i.step) begin
      rx_q   <= xa[7:0];
      ry_q   <= ya[7:0];
      rw_q   <= xw[7:0];
      rh_q   <= yh[7:0];
      rc_q   <= rgb_q;
      has_q  <= 1'b1;
      last_q <= 1'b0;
      adv_q  <= '0;
    end
  end

  assign valid_o       = valid_q;
  assign rect_x_o      = rx_q;
  assign rect_y_o      = ry_q;
  assign rect_w_o      = rw_q;
  assign rect_h_o      = rh_q;
  assign rect_colour_o = rc_q;
  assign has_rect_o    = has_q;
  assign advance_o     = adv_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

>>> rtl/scaled_glyph_rect_rasterizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_glyph_rect_rasterizer_unit
// Rasterizes one scaled 5x7 character into clipped fill rectangles.
// ----------------------------------------------------------------------------
// order: a start loads the character, each dot is scanned and a hit is registered as a rectangle, then the closing item
// throughput: one glyph dot scanned per cycle plus one close
// the next start is taken in the cycle of the closing item, busy is high while scanning
// results are one-cycle strobes on valid_o; the receiver cannot stall
// reset clears the sequencer and the result strobe, payload registers are not reset
module scaled_glyph_rect_rasterizer_unit #(
  parameter int unsigned SCREEN_W = sgrr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = sgrr_pkg::SCREEN_H_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [7:0]         scale_i,
  input  wire logic [15:0]        colour_i,
  output logic                    valid_o,
  output logic [7:0]              rect_x_o,
  output logic [7:0]              rect_y_o,
  output logic [7:0]              rect_w_o,
  output logic [7:0]              rect_h_o,
  output logic [15:0]             rect_colour_o,
  output logic                    has_rect_o,
  output logic [10:0]             advance_o,
  output logic                    last_o
);

  sgrr_pkg::cmd_t    cmd;
  sgrr_pkg::status_t status;

  sgrr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sgrr_dpath #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .char_code_i   (char_code_i),
    .scale_i       (scale_i),
    .colour_i      (colour_i),
    .valid_o       (valid_o),
    .rect_x_o      (rect_x_o),
    .rect_y_o      (rect_y_o),
    .rect_w_o      (rect_w_o),
    .rect_h_o      (rect_h_o),
    .rect_colour_o (rect_colour_o),
    .has_rect_o    (has_rect_o),
    .advance_o     (advance_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
